[rtl/csnm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// csnm_pkg
// Shared types, constants and helpers of the colour sample nearest-match
// classifier: request/result payloads, reference entries, controller states
// and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package csnm_pkg;

    localparam int SAMPLE_W  = 15;               // one pulse-width reading
    localparam int SAMPLE_MAX = 32767;           // largest reading value
    localparam int TRIPLE_N  = 3;                // readings per average
    localparam int TRIPLE_W  = 17;               // sum of three readings
    localparam int ERR_W     = 17;               // sum of three abs diffs
    localparam int LIMIT_W   = 16;
    localparam int INDEX_W   = 4;
    localparam int ENTRY_W   = 8;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd500;
    localparam logic [LIMIT_W-1:0] ERROR_CAP   = 16'hFFFF;

    localparam logic KIND_DETECT = 1'b0;
    localparam logic KIND_CAL    = 1'b1;

    // Colour channel codes, also the steps of a divide sequence.
    localparam logic [1:0] CH_RED    = 2'd0;
    localparam logic [1:0] CH_GREEN  = 2'd1;
    localparam logic [1:0] CH_BLUE   = 2'd2;
    localparam logic [1:0] STEP_LAST = 2'd3;

    typedef struct packed {
        logic                kind;
        logic [ENTRY_W-1:0]  entry;
        logic [SAMPLE_W-1:0] red_width;
        logic [SAMPLE_W-1:0] green_width;
        logic [SAMPLE_W-1:0] blue_width;
    } req_t;

    typedef struct packed {
        logic               report_kind;
        logic [INDEX_W-1:0] colour_index;
        logic               known;
        logic [LIMIT_W-1:0] match_error;
    } res_t;

    typedef struct packed {
        logic                cal;
        logic [SAMPLE_W-1:0] r;
        logic [SAMPLE_W-1:0] g;
        logic [SAMPLE_W-1:0] b;
    } ref_entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACCUM,
        S_DIV3,
        S_SCAN,
        S_REPORT,
        S_TOTAL,
        S_CDIV
    } state_t;

    typedef struct packed {
        logic       load;
        logic       accum;
        logic       mul_go;
        logic       mul_cal;
        logic [1:0] chan;
        logic       avg_wr;
        logic       sums_clr;
        logic       scan_init;
        logic       scan_step;
        logic       tot_add;
        logic       tbl_wr;
        logic       run_clr;
        logic       emit_det;
        logic       emit_cal;
    } cmd_t;

    typedef struct packed {
        logic kind;
        logic skip;
        logic triple_last;
        logic cal_last;
        logic scan_last;
    } sts_t;

    function automatic logic [SAMPLE_W-1:0] absdiff(input logic [SAMPLE_W-1:0] a,
                                                    input logic [SAMPLE_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // Reset content of the reference table: six built-in colours.
    function automatic ref_entry_t builtin_ref(input int unsigned idx);
        ref_entry_t e;
        e = '0;
        case (idx)
            0: e = '{cal: 1'b1, r: 15'd26,  g: 15'd119, b: 15'd89};
            1: e = '{cal: 1'b1, r: 15'd151, g: 15'd76,  b: 15'd88};
            2: e = '{cal: 1'b1, r: 15'd162, g: 15'd142, b: 15'd85};
            3: e = '{cal: 1'b1, r: 15'd19,  g: 15'd32,  b: 15'd62};
            4: e = '{cal: 1'b1, r: 15'd20,  g: 15'd22,  b: 15'd18};
            5: e = '{cal: 1'b1, r: 15'd190, g: 15'd209, b: 15'd173};
            default: e = '0;
        endcase
        return e;
    endfunction

endpackage
`default_nettype wire

[rtl/csnm_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// csnm_ctrl
// Controller: sequences accumulate, divide, scan or total, and report steps of the
// datapath for one request at a time.
// ----------------------------------------------------------------------------
module csnm_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire csnm_pkg::sts_t sts,
    output csnm_pkg::cmd_t     cmd
);

    csnm_pkg::state_t state_reg, state_next;
    logic [1:0]       step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= csnm_pkg::S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            csnm_pkg::S_IDLE:
                if (start) state_next = csnm_pkg::S_ACCUM;
            csnm_pkg::S_ACCUM:
                if (sts.skip || !sts.triple_last) state_next = csnm_pkg::S_IDLE;
                else                              state_next = csnm_pkg::S_DIV3;
            csnm_pkg::S_DIV3:
                if (step_reg == csnm_pkg::STEP_LAST)
                    state_next = (sts.kind == csnm_pkg::KIND_CAL) ? csnm_pkg::S_TOTAL
                                                                  : csnm_pkg::S_SCAN;
            csnm_pkg::S_SCAN:
                if (sts.scan_last) state_next = csnm_pkg::S_REPORT;
            csnm_pkg::S_REPORT:
                state_next = csnm_pkg::S_IDLE;
            csnm_pkg::S_TOTAL:
                state_next = sts.cal_last ? csnm_pkg::S_CDIV : csnm_pkg::S_IDLE;
            csnm_pkg::S_CDIV:
                if (step_reg == csnm_pkg::STEP_LAST) state_next = csnm_pkg::S_IDLE;
            default:
                state_next = csnm_pkg::S_IDLE;
        endcase
    end

    // Step counter advances only inside the divide sequences
    always_comb
    begin
        step_next = '0;
        if (state_reg == csnm_pkg::S_DIV3 || state_reg == csnm_pkg::S_CDIV)
            step_next = step_reg + 2'd1;
    end

    // Outputs
    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            csnm_pkg::S_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            csnm_pkg::S_ACCUM:
                cmd.accum = !sts.skip;
            csnm_pkg::S_DIV3:
            begin
                cmd.chan   = step_reg;
                cmd.mul_go = (step_reg != csnm_pkg::STEP_LAST);
                cmd.avg_wr = (step_reg != csnm_pkg::CH_RED);
                if (step_reg == csnm_pkg::STEP_LAST)
                begin
                    cmd.sums_clr  = 1'b1;
                    cmd.scan_init = 1'b1;
                end
            end
            csnm_pkg::S_SCAN:
                cmd.scan_step = 1'b1;
            csnm_pkg::S_REPORT:
                cmd.emit_det = 1'b1;
            csnm_pkg::S_TOTAL:
                cmd.tot_add = 1'b1;
            csnm_pkg::S_CDIV:
            begin
                cmd.chan    = step_reg;
                cmd.mul_cal = 1'b1;
                cmd.mul_go  = (step_reg != csnm_pkg::STEP_LAST);
                cmd.tbl_wr  = (step_reg != csnm_pkg::CH_RED);
                if (step_reg == csnm_pkg::STEP_LAST)
                begin
                    cmd.run_clr  = 1'b1;
                    cmd.emit_cal = 1'b1;
                end
            end
            default:
                cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

[rtl/csnm_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// csnm_dp
// Datapath: run accumulators, shared reciprocal multiplier for the divides,
// reference table, nearest-entry scan and result register.
// ----------------------------------------------------------------------------
module csnm_dp #(
    parameter int ENTRIES      = 8,
    parameter int CAL_AVERAGES = 10
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire csnm_pkg::req_t                request,
    input  wire csnm_pkg::cmd_t                cmd,
    output csnm_pkg::sts_t                     sts,
    input  wire logic                          cfg_valid,
    input  wire logic [csnm_pkg::LIMIT_W-1:0]  cfg_data,
    output logic                               done,
    output csnm_pkg::res_t                     result
);

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int TOT_W  = $clog2(CAL_AVERAGES * csnm_pkg::SAMPLE_MAX + 1);
    localparam int CNT_W  = $clog2(CAL_AVERAGES + 1);
    localparam int S3     = csnm_pkg::TRIPLE_W + 2;
    localparam int SC     = TOT_W + $clog2(CAL_AVERAGES);
    localparam int OP_W   = (TOT_W > csnm_pkg::TRIPLE_W) ? TOT_W : csnm_pkg::TRIPLE_W;
    localparam int K_W    = ((SC > S3) ? SC : S3) + 1;
    localparam int PROD_W = OP_W + K_W;
    localparam logic [K_W-1:0] M3_K = K_W'(((64'd1 << S3) + 64'd2) / 64'd3);
    localparam logic [K_W-1:0] MC_K =
        K_W'(((64'd1 << SC) + 64'(CAL_AVERAGES) - 64'd1) / 64'(CAL_AVERAGES));

    localparam int SW = csnm_pkg::SAMPLE_W;

    csnm_pkg::req_t          in_reg;
    csnm_pkg::ref_entry_t    tbl_reg [ENTRIES];
    logic [csnm_pkg::TRIPLE_W-1:0] sums_reg [3];
    logic [TOT_W-1:0]        totals_reg [3];
    logic [SW-1:0]           avg_reg [3];
    logic [1:0]              triple_cnt_reg;
    logic [CNT_W-1:0]        avg_cnt_reg;
    logic                    run_kind_reg;
    logic [IDX_W-1:0]        run_entry_reg;
    logic [csnm_pkg::LIMIT_W-1:0] limit_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic [1:0]              mul_chan_reg;
    logic                    mul_cal_reg;
    logic [IDX_W-1:0]        scan_idx_reg;
    logic                    found_reg;
    logic [IDX_W-1:0]        best_idx_reg;
    logic [csnm_pkg::ERR_W-1:0] best_err_reg;
    logic                    done_reg;
    csnm_pkg::res_t          result_reg;

    logic                    restart;
    logic [1:0]              base_cnt;
    logic [SW-1:0]           in_w [3];
    logic [OP_W-1:0]         mul_op;
    logic [K_W-1:0]          mul_k;
    logic [PROD_W-1:0]       prod_next;
    logic [PROD_W-1:0]       prod_sh3;
    logic [PROD_W-1:0]       prod_shc;
    logic [SW-1:0]           quot;
    csnm_pkg::ref_entry_t    scan_e;
    logic [csnm_pkg::ERR_W-1:0] scan_err;
    logic                    scan_better;

    assign in_w[0] = in_reg.red_width;
    assign in_w[1] = in_reg.green_width;
    assign in_w[2] = in_reg.blue_width;

    // A change of kind, or of entry while calibrating, restarts the run
    assign restart = (in_reg.kind != run_kind_reg)
                  || (in_reg.kind == csnm_pkg::KIND_CAL
                      && in_reg.entry != csnm_pkg::ENTRY_W'(run_entry_reg));
    assign base_cnt = restart ? 2'd0 : triple_cnt_reg;

    always_comb
    begin
        sts.kind        = in_reg.kind;
        sts.skip        = (in_reg.kind == csnm_pkg::KIND_CAL)
                       && (in_reg.entry >= csnm_pkg::ENTRY_W'(ENTRIES));
        sts.triple_last = (base_cnt == 2'(csnm_pkg::TRIPLE_N - 1));
        sts.cal_last    = (avg_cnt_reg == CNT_W'(CAL_AVERAGES - 1));
        sts.scan_last   = (scan_idx_reg == IDX_W'(ENTRIES - 1));
    end

    // Shared reciprocal multiplier: floor(x / d) = (x * ceil(2^S / d)) >> S
    always_comb
    begin
        if (cmd.mul_cal)
        begin
            mul_op = OP_W'(totals_reg[cmd.chan]);
            mul_k  = MC_K;
        end
        else
        begin
            mul_op = OP_W'(sums_reg[cmd.chan]);
            mul_k  = M3_K;
        end
        prod_next = PROD_W'(mul_op) * PROD_W'(mul_k);
    end

    assign prod_sh3 = prod_reg >> S3;
    assign prod_shc = prod_reg >> SC;
    assign quot     = mul_cal_reg ? prod_shc[SW-1:0] : prod_sh3[SW-1:0];

    // Error of the entry under the scan pointer
    always_comb
    begin
        scan_e   = tbl_reg[scan_idx_reg];
        scan_err = csnm_pkg::ERR_W'(csnm_pkg::absdiff(avg_reg[0], scan_e.r))
                 + csnm_pkg::ERR_W'(csnm_pkg::absdiff(avg_reg[1], scan_e.g))
                 + csnm_pkg::ERR_W'(csnm_pkg::absdiff(avg_reg[2], scan_e.b));
        scan_better = scan_e.cal && (!found_reg || scan_err < best_err_reg);
    end

    // Run state, table, configuration and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
                tbl_reg[i] <= csnm_pkg::builtin_ref(i);
            for (int c = 0; c < 3; c++)
            begin
                sums_reg[c]   <= '0;
                totals_reg[c] <= '0;
            end
            triple_cnt_reg <= '0;
            avg_cnt_reg    <= '0;
            run_kind_reg   <= csnm_pkg::KIND_DETECT;
            run_entry_reg  <= '0;
            limit_reg      <= csnm_pkg::LIMIT_RESET;
            done_reg       <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.emit_det || cmd.emit_cal;

            if (cfg_valid)
                limit_reg <= cfg_data;

            if (cmd.accum)
            begin
                run_kind_reg <= in_reg.kind;
                if (in_reg.kind == csnm_pkg::KIND_CAL)
                    run_entry_reg <= in_reg.entry[IDX_W-1:0];
                for (int c = 0; c < 3; c++)
                    sums_reg[c] <= (restart ? '0 : sums_reg[c])
                                 + csnm_pkg::TRIPLE_W'(in_w[c]);
                triple_cnt_reg <= sts.triple_last ? 2'd0 : base_cnt + 2'd1;
                if (restart)
                begin
                    for (int c = 0; c < 3; c++)
                        totals_reg[c] <= '0;
                    avg_cnt_reg <= '0;
                end
            end

            if (cmd.sums_clr)
                for (int c = 0; c < 3; c++)
                    sums_reg[c] <= '0;

            if (cmd.tot_add)
            begin
                for (int c = 0; c < 3; c++)
                    totals_reg[c] <= totals_reg[c] + TOT_W'(avg_reg[c]);
                avg_cnt_reg <= avg_cnt_reg + CNT_W'(1);
            end

            if (cmd.tbl_wr)
            begin
                case (mul_chan_reg)
                    csnm_pkg::CH_RED:   tbl_reg[run_entry_reg].r <= quot;
                    csnm_pkg::CH_GREEN: tbl_reg[run_entry_reg].g <= quot;
                    csnm_pkg::CH_BLUE:  tbl_reg[run_entry_reg].b <= quot;
                    default:            ;
                endcase
            end

            if (cmd.run_clr)
            begin
                tbl_reg[run_entry_reg].cal <= 1'b1;
                for (int c = 0; c < 3; c++)
                    totals_reg[c] <= '0;
                avg_cnt_reg <= '0;
            end
        end
    end

    // Payload, multiplier, average, scan and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            in_reg <= request;

        if (cmd.mul_go)
        begin
            prod_reg     <= prod_next;
            mul_chan_reg <= cmd.chan;
            mul_cal_reg  <= cmd.mul_cal;
        end

        if (cmd.avg_wr)
            avg_reg[mul_chan_reg] <= quot;

        if (cmd.scan_init)
        begin
            scan_idx_reg <= '0;
            found_reg    <= 1'b0;
        end
        else if (cmd.scan_step)
        begin
            scan_idx_reg <= scan_idx_reg + IDX_W'(1);
            if (scan_better)
            begin
                found_reg    <= 1'b1;
                best_idx_reg <= scan_idx_reg;
                best_err_reg <= scan_err;
            end
        end

        if (cmd.emit_det)
        begin
            result_reg.report_kind <= csnm_pkg::KIND_DETECT;
            if (found_reg)
            begin
                result_reg.colour_index <= csnm_pkg::INDEX_W'(best_idx_reg);
                result_reg.known        <= (best_err_reg
                                            <= csnm_pkg::ERR_W'(limit_reg));
                result_reg.match_error  <= best_err_reg[csnm_pkg::ERR_W-1]
                                           ? csnm_pkg::ERROR_CAP
                                           : best_err_reg[csnm_pkg::LIMIT_W-1:0];
            end
            else
            begin
                result_reg.colour_index <= '0;
                result_reg.known        <= 1'b0;
                result_reg.match_error  <= csnm_pkg::ERROR_CAP;
            end
        end
        else if (cmd.emit_cal)
        begin
            result_reg.report_kind  <= csnm_pkg::KIND_CAL;
            result_reg.colour_index <= csnm_pkg::INDEX_W'(run_entry_reg);
            result_reg.known        <= 1'b0;
            result_reg.match_error  <= '0;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held longer than one cycle");

    a_cal_report: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && result_reg.report_kind == csnm_pkg::KIND_CAL
        |-> !result_reg.known && result_reg.match_error == '0)
        else $error("calibration report carries match fields");

    a_tbl_wr_cal: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.tbl_wr |-> run_kind_reg == csnm_pkg::KIND_CAL && !sts.skip)
        else $error("table written outside a calibration run");

    a_scan_detect: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_step |-> run_kind_reg == csnm_pkg::KIND_DETECT)
        else $error("scan running outside a detect run");

endmodule
`default_nettype wire

[rtl/colour_sample_nearest_match.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// colour_sample_nearest_match
// Nearest-centroid colour classifier over raw red/green/blue pulse widths,
// with on-line calibration of its reference entries.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel: drive request and raise start; the request is taken at
//    a rising edge with start high and busy low.
//  - Result channel: done strobes for exactly one cycle with result valid.
//    The receiver cannot stall; capture the result in that cycle.
//  - Config channel: cfg_valid/cfg_ready write match_limit (cfg_ready is
//    always high). Write it only while the block is idle.
// Sequencing (ENTRIES entries):
//  - A request that only adds to the running triple ends after accumulating.
//  - The third detect request divides, then scans the table, visiting one
//    table entry per cycle, and reports.
//  - A third calibrate request divides and adds to the totals; the last one
//    of a calibration run also divides the totals. Each divide uses the
//    shared multiplier one channel per cycle.
//  - done rises in the cycle after the request's work ends.
// Reset: the table holds the six built-in colours, run state is cleared,
// match_limit is 500.
// ----------------------------------------------------------------------------
module colour_sample_nearest_match #(
    parameter int ENTRIES      = 8,
    parameter int CAL_AVERAGES = 10
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire csnm_pkg::req_t                request,
    output logic                               done,
    output csnm_pkg::res_t                     result,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [csnm_pkg::LIMIT_W-1:0]  cfg_data
);

    csnm_pkg::cmd_t cmd;
    csnm_pkg::sts_t sts;

    // Config writes go straight into the limit register; never hold them off.
    assign cfg_ready = 1'b1;

    // Sequence each request: accumulate, divide, scan or total, report.
    csnm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    // Hold run state, reference table and the result register.
    csnm_dp #(
        .ENTRIES      (ENTRIES),
        .CAL_AVERAGES (CAL_AVERAGES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .done      (done),
        .result    (result)
    );

endmodule
`default_nettype wire
